>>> hw/rtl/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the console line editor with history.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int BUF_DEPTH_DEF    = 64;
   localparam int HIST_ENTRIES_DEF = 10;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0] CH_DEL  = 8'h7f;
   localparam logic [7:0] CH_ESC  = 8'h1b;
   localparam logic [7:0] CH_EOF  = 8'h04;
   localparam logic [7:0] CH_KILL = 8'h15;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_DUMP = 8'h10;
   localparam logic [7:0] CH_CR   = 8'h0d;
   localparam logic [7:0] CH_LF   = 8'h0a;
   localparam logic [7:0] CH_LBR  = 8'h5b;
   localparam logic [7:0] CH_UPA  = 8'h41;
   localparam logic [7:0] CH_UPB  = 8'h42;

   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      KIND_ECHO  = 2'd0,
      KIND_ERASE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_DUMP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RST_DATA  = 2'd0,
      RST_EOL   = 2'd1,
      RST_EOF   = 2'd2,
      RST_EMPTY = 2'd3
   } rstat_type;

   typedef enum logic [1:0] {
      ESC_NORMAL  = 2'd0,
      ESC_SEEN    = 2'd1,
      ESC_BRACKET = 2'd2
   } esc_type;

   typedef enum logic [2:0] {
      CMD_CHAR,
      CMD_DUMP,
      CMD_KILL,
      CMD_RUBOUT,
      CMD_OLDER,
      CMD_NEWER,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] ch;
      logic       first;
   } entry_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_char;
      logic [6:0] erase_count;
      rstat_type  status;
      logic       committed;
      logic       last;
   } result_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DUMP,
      BK_ERASE,
      BK_ECHO,
      BK_SAVE_INIT,
      BK_SAVE_RD,
      BK_SAVE_WR,
      BK_RC_INIT,
      BK_RC_RD,
      BK_RC_WR,
      BK_READ_CHK,
      BK_READ_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_front
// Accept requests, track escape sequences and classify into commands.
// ----------------------------------------------------------------------------
module cle_front
   import cle_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_opcode,
   input  logic [7:0] req_char,
   input  logic      req_first,
   input  logic      q_full,
   output logic      push,
   output entry_type push_entry
);

   esc_type esc_ff, esc_in;
   logic    accept;
   logic    plain;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= ESC_NORMAL;
      end else begin
         esc_ff <= esc_in;
      end
   end

   always_comb begin
      esc_in           = esc_ff;
      push             = 1'b0;
      plain            = 1'b0;
      push_entry.cmd   = CMD_READ;
      push_entry.ch    = req_char;
      push_entry.first = req_first;
      if (accept) begin
         if (req_opcode == OP_READ) begin
            push = 1'b1;
         end else begin
            case (esc_ff)
               ESC_SEEN: begin
                  esc_in = ESC_NORMAL;
                  if (req_char == CH_LBR) esc_in = ESC_BRACKET;
                  else plain = 1'b1;
               end
               ESC_BRACKET: begin
                  esc_in = ESC_NORMAL;
                  if (req_char == CH_UPA) begin
                     push           = 1'b1;
                     push_entry.cmd = CMD_OLDER;
                  end else if (req_char == CH_UPB) begin
                     push           = 1'b1;
                     push_entry.cmd = CMD_NEWER;
                  end else begin
                     plain = 1'b1;
                  end
               end
               default: begin
                  esc_in = ESC_NORMAL;
                  if (req_char == CH_ESC) esc_in = ESC_SEEN;
                  else plain = 1'b1;
               end
            endcase
            if (plain) begin
               if (req_char == CH_DUMP) begin
                  push           = 1'b1;
                  push_entry.cmd = CMD_DUMP;
               end else if (req_char == CH_KILL) begin
                  push           = 1'b1;
                  push_entry.cmd = CMD_KILL;
               end else if (req_char == CH_BS || req_char == CH_DEL) begin
                  push           = 1'b1;
                  push_entry.cmd = CMD_RUBOUT;
               end else if (req_char != 8'h00) begin
                  push           = 1'b1;
                  push_entry.cmd = CMD_CHAR;
                  if (req_char == CH_CR) push_entry.ch = CH_LF;
               end
            end
         end
      end
   end

endmodule

>>> hw/rtl/cle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module cle_queue
   import cle_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      valid,
   output entry_type head,
   input  logic      pop
);

   localparam int QW = $clog2(QUEUE_DEPTH);

   entry_type      slot_ff [QUEUE_DEPTH];
   logic [QW-1:0]  wr_ff, wr_in;
   logic [QW-1:0]  rd_ff, rd_in;
   logic [QW:0]    cnt_ff, cnt_in;
   logic           do_pop;

   assign full   = (cnt_ff == (QW+1)'(QUEUE_DEPTH));
   assign valid  = (cnt_ff != '0);
   assign head   = slot_ff[rd_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QW+1)'(push) - (QW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/cle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_back
// Sequencer: edits the line buffer, keeps history and delivers results.
// ----------------------------------------------------------------------------
module cle_back
   import cle_pkg::*;
#(
   parameter int BUF_DEPTH    = BUF_DEPTH_DEF,
   parameter int HIST_ENTRIES = HIST_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   localparam int PW  = $clog2(2 * BUF_DEPTH);
   localparam int IW  = $clog2(BUF_DEPTH);
   localparam int SW  = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;
   localparam int CW  = $clog2(HIST_ENTRIES + 1);
   localparam int HD  = HIST_ENTRIES * BUF_DEPTH;
   localparam int HAW = $clog2(HD);
   localparam logic [PW:0]   SPAN  = (PW+1)'(2 * BUF_DEPTH);
   localparam logic [PW-1:0] PMAX  = PW'(2 * BUF_DEPTH - 1);
   localparam logic [PW-1:0] DEPTH = PW'(BUF_DEPTH);

   function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] p);
      return (p == PMAX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] p_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] t;
      t = {1'b0, a} - {1'b0, b};
      if (a < b) t = t + SPAN;
      return t[PW-1:0];
   endfunction

   function automatic logic [IW-1:0] p_idx(input logic [PW-1:0] p);
      logic [PW-1:0] t;
      t = (p >= DEPTH) ? p - DEPTH : p;
      return t[IW-1:0];
   endfunction

   back_state_type state_ff, state_in;

   logic [PW-1:0] rd_ff, rd_in, cm_ff, cm_in, ed_ff, ed_in, src_ff, src_in, lstart_ff, lstart_in;
   logic [PW-1:0] ers_ff, ers_in;
   logic          ers_more_ff, ers_more_in;
   logic [7:0]    chr_ff, chr_in;
   logic          first_ff, first_in;
   logic          commit_ff, commit_in;
   rstat_type     status_ff, status_in;
   logic [IW-1:0] i_ff, i_in, len_ff, len_in;
   logic [SW-1:0] slot_ff, slot_in, newest_ff, newest_in;
   logic [CW-1:0] hcnt_ff, hcnt_in, browse_ff, browse_in;
   logic [IW-1:0] hlen_ff [HIST_ENTRIES];
   logic          hlen_we;

   logic          out_valid_ff, out_valid_in;
   result_type    out_ff, out_in;
   logic          out_free, out_load;
   result_type    res;

   logic            lb_we, lb_re;
   logic [IW-1:0]   lb_waddr, lb_raddr;
   logic [7:0]      lb_wdata, lb_rdata;
   logic            hs_we, hs_re;
   logic [HAW-1:0]  hs_addr;
   logic [7:0]      hs_rdata;

   logic [PW-1:0]   ed_next, len_full, len_trim;
   logic [CW:0]     slot_t;
   logic [CW-1:0]   off;
   logic [IW:0]     i_next;
   logic            more;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign hs_addr   = HAW'(slot_ff) * HAW'(BUF_DEPTH) + HAW'(i_ff);

   cle_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (lb_waddr),
      .wr_data (lb_wdata),
      .rd_en   (lb_re),
      .rd_addr (lb_raddr),
      .rd_data (lb_rdata)
   );

   cle_ram #(.WIDTH(8), .DEPTH(HD)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hs_we),
      .wr_addr (hs_addr),
      .wr_data (lb_rdata),
      .rd_en   (hs_re),
      .rd_addr (hs_addr),
      .rd_data (hs_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      rd_in       = rd_ff;
      cm_in       = cm_ff;
      ed_in       = ed_ff;
      src_in      = src_ff;
      lstart_in   = lstart_ff;
      ers_in      = ers_ff;
      ers_more_in = ers_more_ff;
      chr_in      = chr_ff;
      first_in    = first_ff;
      commit_in   = commit_ff;
      status_in   = status_ff;
      i_in        = i_ff;
      len_in      = len_ff;
      slot_in     = slot_ff;
      newest_in   = newest_ff;
      hcnt_in     = hcnt_ff;
      browse_in   = browse_ff;
      hlen_we     = 1'b0;
      q_pop       = 1'b0;
      out_load    = 1'b0;
      res         = '{kind: KIND_ECHO, out_char: 8'h00, erase_count: 7'd0,
                      status: RST_DATA, committed: 1'b0, last: 1'b1};
      lb_we       = 1'b0;
      lb_waddr    = p_idx(ed_ff);
      lb_wdata    = q_head.ch;
      lb_re       = 1'b0;
      lb_raddr    = p_idx(rd_ff);
      hs_we       = 1'b0;
      hs_re       = 1'b0;
      ed_next     = p_inc(ed_ff);
      len_full    = p_diff(ed_ff, lstart_ff);
      len_trim    = len_full;
      off         = browse_ff - 1'b1;
      slot_t      = '0;
      i_next      = {1'b0, i_ff} + 1'b1;
      more        = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               chr_in   = q_head.ch;
               first_in = q_head.first;
               case (q_head.cmd)
                  CMD_DUMP: state_in = BK_DUMP;
                  CMD_KILL: begin
                     if (ed_ff != cm_ff) begin
                        ers_in      = p_diff(ed_ff, cm_ff);
                        ers_more_in = 1'b0;
                        ed_in       = cm_ff;
                        state_in    = BK_ERASE;
                     end
                  end
                  CMD_RUBOUT: begin
                     if (ed_ff != cm_ff) begin
                        ers_in      = PW'(1);
                        ers_more_in = 1'b0;
                        ed_in       = (ed_ff == '0) ? PMAX : ed_ff - 1'b1;
                        state_in    = BK_ERASE;
                     end
                  end
                  CMD_CHAR: begin
                     if (p_diff(ed_ff, rd_ff) < DEPTH) begin
                        lb_we  = 1'b1;
                        ed_in  = ed_next;
                        commit_in = (q_head.ch == CH_LF) || (q_head.ch == CH_EOF) ||
                                    (p_diff(ed_next, rd_ff) == DEPTH);
                        if (commit_in) begin
                           lstart_in = cm_ff;
                           cm_in     = ed_next;
                           browse_in = '0;
                        end
                        state_in = BK_ECHO;
                     end
                  end
                  CMD_OLDER, CMD_NEWER: begin
                     if (hcnt_ff != '0) begin
                        if (q_head.cmd == CMD_OLDER) begin
                           if (browse_ff < hcnt_ff) browse_in = browse_ff + 1'b1;
                        end else begin
                           browse_in = (browse_ff > CW'(1)) ? browse_ff - 1'b1 : CW'(1);
                        end
                        ers_in   = p_diff(ed_ff, cm_ff);
                        ed_in    = cm_ff;
                        state_in = BK_RC_INIT;
                     end
                  end
                  CMD_READ: begin
                     if (rd_ff == cm_ff) begin
                        status_in = RST_EMPTY;
                        chr_in    = 8'h00;
                        state_in  = BK_READ_EMIT;
                     end else begin
                        lb_re    = 1'b1;
                        state_in = BK_READ_CHK;
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_DUMP: begin
            res.kind = KIND_DUMP;
            if (out_free) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_ERASE: begin
            res.kind        = KIND_ERASE;
            res.erase_count = 7'(ers_ff);
            res.last        = !ers_more_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ers_more_ff ? BK_RC_RD : BK_IDLE;
            end
         end
         BK_ECHO: begin
            res.out_char  = chr_ff;
            res.committed = commit_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = commit_ff ? BK_SAVE_INIT : BK_IDLE;
            end
         end
         BK_SAVE_INIT: begin
            // Drop the line terminator and trim to what one slot holds.
            if (chr_ff == CH_LF) len_trim = len_full - 1'b1;
            if (len_trim > PW'(BUF_DEPTH - 1)) len_trim = PW'(BUF_DEPTH - 1);
            len_in  = IW'(len_trim);
            i_in    = '0;
            src_in  = lstart_ff;
            if (hcnt_ff == '0 || newest_ff == SW'(HIST_ENTRIES - 1)) slot_in = '0;
            else slot_in = newest_ff + 1'b1;
            state_in = (len_full > PW'(1)) ? BK_SAVE_RD : BK_IDLE;
         end
         BK_SAVE_RD: begin
            lb_re    = 1'b1;
            lb_raddr = p_idx(src_ff);
            state_in = BK_SAVE_WR;
         end
         BK_SAVE_WR: begin
            hs_we  = 1'b1;
            i_in   = i_next[IW-1:0];
            src_in = p_inc(src_ff);
            if (i_next == {1'b0, len_ff}) begin
               hlen_we   = 1'b1;
               newest_in = slot_ff;
               if (hcnt_ff < CW'(HIST_ENTRIES)) hcnt_in = hcnt_ff + 1'b1;
               state_in  = BK_IDLE;
            end else begin
               state_in = BK_SAVE_RD;
            end
         end
         BK_RC_INIT: begin
            slot_t = {{(CW+1-SW){1'b0}}, newest_ff} - {1'b0, off};
            if ({{(CW-SW){1'b0}}, newest_ff} < off) slot_t = slot_t + (CW+1)'(HIST_ENTRIES);
            slot_in = slot_t[SW-1:0];
            len_in  = hlen_ff[slot_t[SW-1:0]];
            i_in    = '0;
            more    = (hlen_ff[slot_t[SW-1:0]] != '0) && (p_diff(ed_ff, rd_ff) < DEPTH);
            ers_more_in = more;
            if (ers_ff != '0) state_in = BK_ERASE;
            else state_in = more ? BK_RC_RD : BK_IDLE;
         end
         BK_RC_RD: begin
            hs_re    = 1'b1;
            state_in = BK_RC_WR;
         end
         BK_RC_WR: begin
            more         = (i_next < {1'b0, len_ff}) && (p_diff(ed_next, rd_ff) < DEPTH);
            res.out_char = hs_rdata;
            res.last     = !more;
            lb_wdata     = hs_rdata;
            if (out_free) begin
               out_load = 1'b1;
               lb_we    = 1'b1;
               ed_in    = ed_next;
               i_in     = i_next[IW-1:0];
               state_in = more ? BK_RC_RD : BK_IDLE;
            end
         end
         BK_READ_CHK: begin
            if (lb_rdata == CH_EOF) begin
               if (first_ff) rd_in = p_inc(rd_ff);
               status_in = RST_EOF;
               chr_in    = 8'h00;
            end else begin
               rd_in     = p_inc(rd_ff);
               status_in = (lb_rdata == CH_LF) ? RST_EOL : RST_DATA;
               chr_in    = lb_rdata;
            end
            state_in = BK_READ_EMIT;
         end
         BK_READ_EMIT: begin
            res.kind     = KIND_READ;
            res.out_char = chr_ff;
            res.status   = status_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_in       = out_load ? res : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_ff        <= '0;
         cm_ff        <= '0;
         ed_ff        <= '0;
         hcnt_ff      <= '0;
         newest_ff    <= '0;
         browse_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         cm_ff        <= cm_in;
         ed_ff        <= ed_in;
         hcnt_ff      <= hcnt_in;
         newest_ff    <= newest_in;
         browse_ff    <= browse_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      lstart_ff   <= lstart_in;
      ers_ff      <= ers_in;
      ers_more_ff <= ers_more_in;
      chr_ff      <= chr_in;
      first_ff    <= first_in;
      commit_ff   <= commit_in;
      status_ff   <= status_in;
      i_ff        <= i_in;
      len_ff      <= len_in;
      slot_ff     <= slot_in;
      out_ff      <= out_in;
      if (hlen_we) begin
         hlen_ff[slot_ff] <= len_ff;
      end
   end

endmodule

>>> hw/rtl/console_line_editor_with_history_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_with_history_core
// Terminal line editor over a ring buffer, with recallable line history.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: tuser = opcode (0 received character,
//   1 reader takes one byte), tdata = rx_char and first_of_read.
//   rsp_* returns zero or more results per request; tlast marks the final
//   result of a request, tuser gives its kind (echo, erase, read, dump).
//   A front classifier tracks ESC [ A / ESC [ B and hands commands to a
//   four-entry queue; the back sequencer executes them one at a time.
// Sequencing:
//   Single-result requests pass the queue and the sequencer before rsp_tvalid
//   rises; a read that finds committed data reads the line RAM first.
//   A committing line then sets up a history slot and copies each saved
//   byte (line RAM read, history RAM write); a recall picks its slot, gives
//   the erase result, then reads and echoes each recalled byte.
//   The queue absorbs bursts of up to four requests while the sequencer
//   works, so input is taken while results are still pending.
// Reset:
//   Synchronous, active high: pointers, escape state, history counters
//   and the output valid flag clear. Buffer and history RAMs need no clear.
// Backpressure:
//   When rsp_tready is low the result register holds its value, the
//   sequencer stalls and the queue fills until req_tready drops.
// ----------------------------------------------------------------------------
module console_line_editor_with_history_core
   import cle_pkg::*;
#(
   parameter int BUF_DEPTH    = BUF_DEPTH_DEF,
   parameter int HIST_ENTRIES = HIST_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] rx_char, [8] first_of_read, rest zero
   input  logic        req_tuser,  // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] out_char, [14:8] erase_count,
                                   // [16:15] read_status, [17] line_committed
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast
);

   // Front to queue.
   logic      q_full, q_push;
   entry_type q_push_entry;
   // Queue to back.
   logic      q_valid, q_pop;
   entry_type q_head;
   // Back result.
   result_type res;

   cle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .req_char   (req_tdata[7:0]),
      .req_first  (req_tdata[8]),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   cle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .valid      (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   cle_back #(
      .BUF_DEPTH    (BUF_DEPTH),
      .HIST_ENTRIES (HIST_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (res)
   );

   // Pack the result fields onto the stream.
   assign rsp_tdata = {6'd0, res.committed, res.status, res.erase_count, res.out_char};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

>>> hw/rtl/cle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the line editor core, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker
   import cle_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_commit_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tuser == KIND_ECHO && rsp_tlast)
      else $error("commit flag on a non-final or non-echo result");

   a_erase_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERASE |-> rsp_tdata[14:8] != 7'd0 &&
      rsp_tdata[7:0] == 8'd0)
      else $error("erase result without a count");

   a_read_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_READ || rsp_tuser == KIND_DUMP) |-> rsp_tlast)
      else $error("read or dump result not final");

   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_READ |-> rsp_tdata[16:15] == 2'd0)
      else $error("status set outside a read result");

endmodule

bind console_line_editor_with_history_core cle_checker u_cle_checker (.*);

>>> tb/console_line_editor_with_history_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_with_history_core_tb
// Self-checking bench for the console line editor with history.
// Drives typed lines, edits, escape recalls and reads with random gaps on
// both sides. A built-in line editor predicts every result, and a monitor
// compares each result, all fields at once, in order.
// ----------------------------------------------------------------------------
module console_line_editor_with_history_core_tb;
   import cle_pkg::*;

   localparam int DEPTH = BUF_DEPTH_DEF;
   localparam int HIST  = HIST_ENTRIES_DEF;
   localparam int SPAN  = 2 * DEPTH;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic       opcode;
      logic [7:0] ch;
      logic       first;
   } request_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   console_line_editor_with_history_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Shadow editor state
   logic [7:0] line_mem [DEPTH];
   logic [7:0] hist_mem [HIST][DEPTH];
   int         hist_len [HIST];
   int         rd_ptr, cm_ptr, ed_ptr;
   esc_type    esc_mode;
   int         hist_count, hist_newest, browse;

   request_type pending_requests[$];
   result_type  expected_results[$];
   int          n_errors, n_checked, n_sent, n_cycles;

   function automatic int ptr_next(int p);
      return (p + 1 >= SPAN) ? 0 : p + 1;
   endfunction

   function automatic int ptr_prev(int p);
      return (p == 0) ? SPAN - 1 : p - 1;
   endfunction

   function automatic int ptr_dist(int a, int b);
      return (a + SPAN - b) % SPAN;
   endfunction

   task automatic push_result(kind_type k, logic [7:0] c, int cnt, rstat_type st,
                              logic com);
      result_type r;
      r.kind        = k;
      r.out_char    = c;
      r.erase_count = cnt[6:0];
      r.status      = st;
      r.committed   = com;
      r.last        = 1'b0;
      expected_results.push_back(r);
   endtask

   task automatic erase_to_commit();
      int n;
      n = 0;
      while (ed_ptr != cm_ptr && line_mem[ptr_prev(ed_ptr) % DEPTH] != CH_LF) begin
         ed_ptr = ptr_prev(ed_ptr);
         n++;
      end
      if (n > 0) push_result(KIND_ERASE, 8'h00, n, RST_DATA, 1'b0);
   endtask

   task automatic recall_line(bit older);
      int slot, len;
      logic [7:0] c;
      if (hist_count == 0) return;
      if (older) begin
         if (browse < hist_count) browse++;
      end else begin
         browse = (browse > 1) ? browse - 1 : 1;
      end
      erase_to_commit();
      slot = (hist_newest + HIST - (browse - 1)) % HIST;
      len = hist_len[slot];
      if (len > DEPTH - 1) len = DEPTH - 1;
      for (int i = 0; i < len && ptr_dist(ed_ptr, rd_ptr) < DEPTH; i++) begin
         c = hist_mem[slot][i];
         line_mem[ed_ptr % DEPTH] = c;
         ed_ptr = ptr_next(ed_ptr);
         push_result(KIND_ECHO, c, 0, RST_DATA, 1'b0);
      end
   endtask

   task automatic save_line(int start);
      int len, slot, p;
      len = ptr_dist(ed_ptr, start);
      if (len <= 1) return;
      if (line_mem[ptr_prev(ed_ptr) % DEPTH] == CH_LF) len--;
      if (len > DEPTH - 1) len = DEPTH - 1;
      slot = (hist_count == 0) ? 0 : (hist_newest + 1) % HIST;
      p = start;
      for (int i = 0; i < len; i++) begin
         hist_mem[slot][i] = line_mem[p % DEPTH];
         p = ptr_next(p);
      end
      hist_len[slot] = len;
      hist_newest = slot;
      if (hist_count < HIST) hist_count++;
   endtask

   task automatic edit_char(logic [7:0] c);
      int start;
      if (esc_mode == ESC_SEEN) begin
         esc_mode = ESC_NORMAL;
         if (c == CH_LBR) begin
            esc_mode = ESC_BRACKET;
            return;
         end
      end else if (esc_mode == ESC_BRACKET) begin
         esc_mode = ESC_NORMAL;
         if (c == CH_UPA) begin recall_line(1'b1); return; end
         if (c == CH_UPB) begin recall_line(1'b0); return; end
      end else if (c == CH_ESC) begin
         esc_mode = ESC_SEEN;
         return;
      end

      if (c == CH_DUMP) begin
         push_result(KIND_DUMP, 8'h00, 0, RST_DATA, 1'b0);
      end else if (c == CH_KILL) begin
         erase_to_commit();
      end else if (c == CH_BS || c == CH_DEL) begin
         if (ed_ptr != cm_ptr) begin
            ed_ptr = ptr_prev(ed_ptr);
            push_result(KIND_ERASE, 8'h00, 1, RST_DATA, 1'b0);
         end
      end else if (c != 8'h00 && ptr_dist(ed_ptr, rd_ptr) < DEPTH) begin
         if (c == CH_CR) c = CH_LF;
         line_mem[ed_ptr % DEPTH] = c;
         ed_ptr = ptr_next(ed_ptr);
         if (c == CH_LF || c == CH_EOF || ptr_dist(ed_ptr, rd_ptr) == DEPTH) begin
            start = cm_ptr;
            cm_ptr = ed_ptr;
            save_line(start);
            browse = 0;
            push_result(KIND_ECHO, c, 0, RST_DATA, 1'b1);
         end else begin
            push_result(KIND_ECHO, c, 0, RST_DATA, 1'b0);
         end
      end
   endtask

   task automatic read_one(logic first);
      logic [7:0] c;
      if (rd_ptr == cm_ptr) begin
         push_result(KIND_READ, 8'h00, 0, RST_EMPTY, 1'b0);
         return;
      end
      c = line_mem[rd_ptr % DEPTH];
      if (c == CH_EOF) begin
         if (first) rd_ptr = ptr_next(rd_ptr);
         push_result(KIND_READ, 8'h00, 0, RST_EOF, 1'b0);
         return;
      end
      rd_ptr = ptr_next(rd_ptr);
      push_result(KIND_READ, c, 0, (c == CH_LF) ? RST_EOL : RST_DATA, 1'b0);
   endtask

   // Predict the results of one accepted request; mark the final one
   task automatic predict_request(request_type rq);
      int n_prior;
      n_prior = expected_results.size();
      if (rq.opcode == OP_RX) edit_char(rq.ch);
      else read_one(rq.first);
      if (expected_results.size() > n_prior)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endtask

   // Driver: hold each request until accepted, then wait a random gap
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold
      end else begin
         if (req_tvalid) begin
            predict_request(pending_requests.pop_front());
            n_sent++;
         end
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_type nx;
            nx = pending_requests[0];
            req_tvalid <= 1'b1;
            req_tuser  <= nx.opcode;
            req_tdata  <= {7'd0, nx.first, nx.ch};
            req_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: compare accepted results, draw random stalls
   int rsp_gap;
   always @(posedge clock) begin
      n_cycles++;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_type got, want;
            got.kind        = kind_type'(rsp_tuser);
            got.out_char    = rsp_tdata[7:0];
            got.erase_count = rsp_tdata[14:8];
            got.status      = rstat_type'(rsp_tdata[16:15]);
            got.committed   = rsp_tdata[17];
            got.last        = rsp_tlast;
            n_checked++;
            if (expected_results.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: unexpected result %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("ERROR: result %0d expected %p got %p", n_checked, want, got);
               end
            end
            rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap    <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_rx(logic [7:0] c);
      request_type rq;
      rq.opcode = OP_RX;
      rq.ch     = c;
      rq.first  = 1'($urandom_range(0, 1));
      pending_requests.push_back(rq);
   endtask

   task automatic add_read(logic first);
      request_type rq;
      rq.opcode = OP_READ;
      rq.ch     = 8'($urandom);
      rq.first  = first;
      pending_requests.push_back(rq);
   endtask

   function automatic logic [7:0] printable();
      return 8'($urandom_range(8'h20, 8'h7e));
   endfunction

   // Stimulus: directed cases first, then randomized editing sessions
   initial begin
      int kind_pick, len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      n_errors = 0; n_checked = 0; n_sent = 0; n_cycles = 0;
      rd_ptr = 0; cm_ptr = 0; ed_ptr = 0; esc_mode = ESC_NORMAL;
      hist_count = 0; hist_newest = 0; browse = 0;

      // recall with empty history, empty read, ignored edits, then a dump, broken escapes, commits and reads
      add_rx(CH_ESC); add_rx(CH_LBR); add_rx(CH_UPA);
      add_read(1'b1); add_rx(CH_BS); add_rx(CH_KILL); add_rx(8'h00);
      add_rx(CH_DUMP);
      add_rx(8'hff); add_rx(8'h80); add_rx(CH_DEL); add_rx(8'h01);
      add_rx(CH_CR);
      add_rx(CH_ESC); add_rx(8'h41);
      add_rx(CH_ESC); add_rx(CH_LBR); add_rx(8'h43);
      add_rx(CH_KILL); add_rx(CH_EOF);
      add_read(1'b1); add_read(1'b0); add_read(1'b0); add_read(1'b1);
      add_read(1'b1);

      // random sessions; stop the buffer from overflowing with unread text only
      // sometimes, so the full-buffer commit is reached as well
      while (pending_requests.size() < 135) begin
         kind_pick = $urandom_range(0, 9);
         if (kind_pick < 4) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                              : $urandom_range(0, 6);
            for (int i = 0; i < len; i++) add_rx(printable());
            if ($urandom_range(0, 3) == 0) add_rx(CH_BS);
            add_rx(($urandom_range(0, 5) == 0) ? CH_EOF
                   : ($urandom_range(0, 1) ? CH_CR : CH_LF));
         end else if (kind_pick < 6) begin
            add_rx(CH_ESC); add_rx(CH_LBR);
            add_rx($urandom_range(0, 1) ? CH_UPA : CH_UPB);
            if ($urandom_range(0, 1)) add_rx(CH_KILL);
            else add_rx(CH_CR);
         end else if (kind_pick < 8) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) add_read(1'($urandom_range(0, 1)));
         end else begin
            add_rx(8'($urandom));
         end
      end
      for (int i = 0; i < 40; i++) add_read(1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pending_requests.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      $display("Run covered %0d requests and %0d results, history depth reached %0d.",
               n_sent, n_checked, hist_count);
      if (n_errors == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Errors: %0d", n_errors);
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   always @(posedge clock) begin
      if (n_cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", n_cycles);
         $display("Verification failed");
         $finish;
      end
   end

endmodule
